@@ hw/rtl/ffra_pkg.sv @@
package ffra_pkg;

  localparam int MAX_RANGES_DEF = 32;
  localparam int RES_BITS_DEF   = 20;
  localparam int SMP_BITS_DEF   = 11;

  localparam int RES_CFG_W  = 21;
  localparam int SMP_CFG_W  = 12;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 1;

  localparam logic [RES_CFG_W-1:0] RES_POOL_RST = RES_CFG_W'(4096);
  localparam logic [SMP_CFG_W-1:0] SMP_POOL_RST = SMP_CFG_W'(2048);

  localparam logic [CFG_IDX_W-1:0] CFG_RES_POOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMP_POOL = 1'b1;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    TC_INIT   = 3'd0,
    TC_FIND   = 3'd1,
    TC_TAKE   = 3'd2,
    TC_PROBE  = 3'd3,
    TC_INSERT = 3'd4
  } tbl_code_t;

  typedef struct packed {
    logic      start;
    tbl_code_t code;
  } tbl_cmd_t;

  typedef struct packed {
    logic busy;
    logic found;
    logic ovf;
  } tbl_stat_t;

endpackage

@@ hw/rtl/first_fit_range_allocator.sv @@
// First-fit allocator over two free-range tables (resource and sampler pools).
// Input channel in_*: one transaction per operation (init, allocate, free);
// each yields exactly one transaction on out_* (status and range starts).
// Config port cfg_*: write pool sizes while idle; used by the next init.
// Both tables run side by side, each under its own small sequencer with one
// read and one write port on its table memory. A walk over the table reads,
// then checks, each entry in turn; each entry moved when an entry is removed
// or inserted is read, then written. Allocate: find plus take; free: probe
// plus insert; init and the unused opcode need no walk. in_ready is high only
// when the block is idle and holds no result; one transaction is in flight
// at a time. A stalled out_ready holds the result and keeps in_ready low.
// Reset empties both tables (no entries) and restores the pool sizes to
// 4096 and 2048; the tables hold no ranges until an init or a free adds them.
module first_fit_range_allocator #(
  parameter int MAX_RANGES          = ffra_pkg::MAX_RANGES_DEF,
  parameter int RESOURCE_INDEX_BITS = ffra_pkg::RES_BITS_DEF,
  parameter int SAMPLER_INDEX_BITS  = ffra_pkg::SMP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [RESOURCE_INDEX_BITS-1:0]      in_cbv_base,
  input  logic [RESOURCE_INDEX_BITS:0]        in_cbv_count,
  input  logic [SAMPLER_INDEX_BITS-1:0]       in_sampler_base,
  input  logic [SAMPLER_INDEX_BITS:0]         in_sampler_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [RESOURCE_INDEX_BITS-1:0]      out_cbv_first,
  output logic [SAMPLER_INDEX_BITS-1:0]       out_sampler_first,
  input  logic                                cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ffra_pkg::*;

  localparam int RB = RESOURCE_INDEX_BITS;
  localparam int SB = SAMPLER_INDEX_BITS;
  localparam int RW = (RES_CFG_W > RB + 1) ? RES_CFG_W : RB + 1;
  localparam int SW = (SMP_CFG_W > SB + 1) ? SMP_CFG_W : SB + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_FIND  = 7'b0000100,
    S_TAKE  = 7'b0001000,
    S_PROBE = 7'b0010000,
    S_INS   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [RES_CFG_W-1:0] res_pool_r, res_pool_nxt;
  logic [SMP_CFG_W-1:0] smp_pool_r, smp_pool_nxt;
  tbl_cmd_t r_cmd_r, r_cmd_nxt, s_cmd_r, s_cmd_nxt;
  logic [RB-1:0] rbase_r, rbase_nxt;
  logic [RB:0]   rcnt_r, rcnt_nxt;
  logic [SB-1:0] sbase_r, sbase_nxt;
  logic [SB:0]   scnt_r, scnt_nxt;
  status_t status_r, status_nxt;
  logic [RB-1:0] rfirst_r, rfirst_nxt;
  logic [SB-1:0] sfirst_r, sfirst_nxt;

  tbl_stat_t r_stat, s_stat;
  logic [RB-1:0] r_hit;
  logic [SB-1:0] s_hit;
  logic [RW-1:0] r_ext, r_lim, r_clip;
  logic [SW-1:0] s_ext, s_lim, s_clip;
  logic r_ok, s_ok;

  // pool sizes clamp to the index space
  always_comb begin
    r_ext  = RW'(res_pool_r);
    r_lim  = RW'(1) << RB;
    r_clip = (r_ext > r_lim) ? r_lim : r_ext;
    s_ext  = SW'(smp_pool_r);
    s_lim  = SW'(1) << SB;
    s_clip = (s_ext > s_lim) ? s_lim : s_ext;
  end

  ffra_table #(.MAX_RANGES(MAX_RANGES), .IDX_BITS(RB)) u_res_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (r_cmd_r),
    .size      ((RB+1)'(r_clip)),
    .count     (rcnt_r),
    .base      (rbase_r),
    .stat      (r_stat),
    .hit_first (r_hit)
  );

  ffra_table #(.MAX_RANGES(MAX_RANGES), .IDX_BITS(SB)) u_smp_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (s_cmd_r),
    .size      ((SB+1)'(s_clip)),
    .count     (scnt_r),
    .base      (sbase_r),
    .stat      (s_stat),
    .hit_first (s_hit)
  );

  assign r_ok = (rcnt_r == '0) || r_stat.found;
  assign s_ok = (scnt_r == '0) || s_stat.found;

  always_comb begin
    res_pool_nxt = res_pool_r;
    smp_pool_nxt = smp_pool_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RES_POOL: res_pool_nxt = cfg_wdata[RES_CFG_W-1:0];
        CFG_SMP_POOL: smp_pool_nxt = cfg_wdata[SMP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    r_cmd_nxt  = '{start: 1'b0, code: TC_INIT};
    s_cmd_nxt  = '{start: 1'b0, code: TC_INIT};
    rbase_nxt  = rbase_r;
    rcnt_nxt   = rcnt_r;
    sbase_nxt  = sbase_r;
    scnt_nxt   = scnt_r;
    status_nxt = status_r;
    rfirst_nxt = rfirst_r;
    sfirst_nxt = sfirst_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rbase_nxt  = in_cbv_base;
          rcnt_nxt   = in_cbv_count;
          sbase_nxt  = in_sampler_base;
          scnt_nxt   = in_sampler_count;
          status_nxt = ST_OK;
          rfirst_nxt = '0;
          sfirst_nxt = '0;
          case (op_t'(in_operation))
            OP_INIT: begin
              r_cmd_nxt = '{start: 1'b1, code: TC_INIT};
              s_cmd_nxt = '{start: 1'b1, code: TC_INIT};
              state_nxt = S_INIT;
            end
            OP_ALLOC: begin
              r_cmd_nxt = '{start: 1'b1, code: TC_FIND};
              s_cmd_nxt = '{start: 1'b1, code: TC_FIND};
              state_nxt = S_FIND;
            end
            OP_FREE: begin
              r_cmd_nxt = '{start: 1'b1, code: TC_PROBE};
              s_cmd_nxt = '{start: 1'b1, code: TC_PROBE};
              state_nxt = S_PROBE;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_INIT, S_TAKE, S_INS: begin
        if (!r_stat.busy && !s_stat.busy) begin
          state_nxt = S_OUT;
        end
      end
      S_FIND: begin
        if (!r_stat.busy && !s_stat.busy) begin
          if (!(r_ok && s_ok)) begin
            // nothing committed on either pool
            status_nxt = ST_NOFIT;
            state_nxt  = S_OUT;
          end else begin
            if (rcnt_r != '0) begin
              rfirst_nxt = r_hit;
              r_cmd_nxt  = '{start: 1'b1, code: TC_TAKE};
            end
            if (scnt_r != '0) begin
              sfirst_nxt = s_hit;
              s_cmd_nxt  = '{start: 1'b1, code: TC_TAKE};
            end
            state_nxt = S_TAKE;
          end
        end
      end
      S_PROBE: begin
        if (!r_stat.busy && !s_stat.busy) begin
          if (r_stat.ovf || s_stat.ovf) begin
            status_nxt = ST_FULL;
            state_nxt  = S_OUT;
          end else begin
            r_cmd_nxt = '{start: 1'b1, code: TC_INSERT};
            s_cmd_nxt = '{start: 1'b1, code: TC_INSERT};
            state_nxt = S_INS;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_pool_r <= RES_POOL_RST;
      smp_pool_r <= SMP_POOL_RST;
      r_cmd_r    <= '{start: 1'b0, code: TC_INIT};
      s_cmd_r    <= '{start: 1'b0, code: TC_INIT};
    end else begin
      state_r    <= state_nxt;
      res_pool_r <= res_pool_nxt;
      smp_pool_r <= smp_pool_nxt;
      r_cmd_r    <= r_cmd_nxt;
      s_cmd_r    <= s_cmd_nxt;
    end
    rbase_r  <= rbase_nxt;
    rcnt_r   <= rcnt_nxt;
    sbase_r  <= sbase_nxt;
    scnt_r   <= scnt_nxt;
    status_r <= status_nxt;
    rfirst_r <= rfirst_nxt;
    sfirst_r <= sfirst_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_status        = status_r;
  assign out_cbv_first     = rfirst_r;
  assign out_sampler_first = sfirst_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_cbv_first == '0 && out_sampler_first == '0)
    else $error("failed transaction carries a range start");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted transaction left the block idle");

endmodule

@@ hw/rtl/ffra_table.sv @@
module ffra_table #(
  parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
  parameter int IDX_BITS   = ffra_pkg::RES_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffra_pkg::tbl_cmd_t   cmd,
  input  logic [IDX_BITS:0]    size,
  input  logic [IDX_BITS:0]    count,
  input  logic [IDX_BITS-1:0]  base,
  output ffra_pkg::tbl_stat_t  stat,
  output logic [IDX_BITS-1:0]  hit_first
);
  import ffra_pkg::*;

  localparam int CB = IDX_BITS + 1;
  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int TW = $clog2(MAX_RANGES + 1);

  typedef struct packed {
    logic [IDX_BITS-1:0] first;
    logic [CB-1:0]       count;
  } ent_t;

  typedef enum logic [5:0] {
    T_IDLE     = 6'b000001,
    T_SCAN_RD  = 6'b000010,
    T_SCAN_CHK = 6'b000100,
    T_SH_RD    = 6'b001000,
    T_SH_WR    = 6'b010000,
    T_FIN_WR   = 6'b100000
  } tstate_t;

  tstate_t state_r, state_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] j_r, j_nxt;
  logic [TW-1:0] pos_r, pos_nxt;
  logic found_r, found_nxt;
  logic probe_r, probe_nxt;
  logic up_r, up_nxt;
  ent_t prev_r, prev_nxt;
  ent_t cur_r, cur_nxt;
  logic [IDX_BITS-1:0] base_r, base_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;

  ent_t mem [MAX_RANGES];
  ent_t rdata_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  ent_t wdata;

  logic [CB:0] prev_end, new_end;
  logic left, right, full, ovf;
  logic [CB-1:0] take_rem, merged, room, clip_cnt;
  logic [IDX_BITS-1:0] take_first;
  logic [TW-1:0] pos_m1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    prev_end   = (CB+1)'(prev_r.first) + (CB+1)'(prev_r.count);
    new_end    = (CB+1)'(base_r) + (CB+1)'(cnt_r);
    left       = (pos_r != '0) && (prev_end == (CB+1)'(base_r));
    right      = (pos_r < total_r) && (new_end == (CB+1)'(cur_r.first));
    full       = (total_r == TW'(MAX_RANGES));
    ovf        = (cnt_r != '0) && !left && !right && full;
    take_rem   = cur_r.count - count;
    take_first = IDX_BITS'(CB'(cur_r.first) + count);
    merged     = prev_r.count + cnt_r + cur_r.count;
    room       = (CB'(1) << IDX_BITS) - CB'(base);
    clip_cnt   = (count > room) ? room : count;
    pos_m1     = pos_r - TW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    j_nxt     = j_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    probe_nxt = probe_r;
    up_nxt    = up_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;
    case (state_r)
      T_IDLE: begin
        if (cmd.start) begin
          case (cmd.code)
            TC_INIT: begin
              we          = 1'b1;
              wdata.count = size;
              total_nxt   = (size != '0) ? TW'(1) : '0;
            end
            TC_FIND: begin
              j_nxt     = '0;
              probe_nxt = 1'b0;
              found_nxt = 1'b0;
              state_nxt = T_SCAN_RD;
            end
            TC_PROBE: begin
              j_nxt     = '0;
              probe_nxt = 1'b1;
              base_nxt  = base;
              cnt_nxt   = clip_cnt;
              state_nxt = T_SCAN_RD;
            end
            TC_TAKE: begin
              if (take_rem != '0) begin
                we    = 1'b1;
                waddr = pos_r[AW-1:0];
                wdata = '{first: take_first, count: take_rem};
              end else begin
                // entry used up: close the gap
                up_nxt = 1'b0;
                j_nxt  = pos_r;
                if (pos_r + TW'(1) < total_r) begin
                  state_nxt = T_SH_RD;
                end else begin
                  total_nxt = total_r - TW'(1);
                end
              end
            end
            TC_INSERT: begin
              if (cnt_r != '0) begin
                if (left && right) begin
                  we     = 1'b1;
                  waddr  = pos_m1[AW-1:0];
                  wdata  = '{first: prev_r.first, count: merged};
                  up_nxt = 1'b0;
                  j_nxt  = pos_r;
                  if (pos_r + TW'(1) < total_r) begin
                    state_nxt = T_SH_RD;
                  end else begin
                    total_nxt = total_r - TW'(1);
                  end
                end else if (left) begin
                  we    = 1'b1;
                  waddr = pos_m1[AW-1:0];
                  wdata = '{first: prev_r.first, count: prev_r.count + cnt_r};
                end else if (right) begin
                  we    = 1'b1;
                  waddr = pos_r[AW-1:0];
                  wdata = '{first: base_r, count: cur_r.count + cnt_r};
                end else if (!full) begin
                  if (pos_r == total_r) begin
                    we        = 1'b1;
                    waddr     = pos_r[AW-1:0];
                    wdata     = '{first: base_r, count: cnt_r};
                    total_nxt = total_r + TW'(1);
                  end else begin
                    up_nxt    = 1'b1;
                    j_nxt     = total_r;
                    state_nxt = T_SH_RD;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      T_SCAN_RD: begin
        if (j_r >= total_r) begin
          state_nxt = T_IDLE;
          if (probe_r) begin
            pos_nxt = j_r;
          end
        end else begin
          raddr     = j_r[AW-1:0];
          state_nxt = T_SCAN_CHK;
        end
      end
      T_SCAN_CHK: begin
        if (probe_r) begin
          if (rdata_r.first < base_r) begin
            prev_nxt  = rdata_r;
            j_nxt     = j_r + TW'(1);
            state_nxt = T_SCAN_RD;
          end else begin
            cur_nxt   = rdata_r;
            pos_nxt   = j_r;
            state_nxt = T_IDLE;
          end
        end else if (rdata_r.count >= count) begin
          found_nxt = 1'b1;
          cur_nxt   = rdata_r;
          pos_nxt   = j_r;
          state_nxt = T_IDLE;
        end else begin
          j_nxt     = j_r + TW'(1);
          state_nxt = T_SCAN_RD;
        end
      end
      T_SH_RD: begin
        raddr     = up_r ? AW'(j_r - TW'(1)) : AW'(j_r + TW'(1));
        state_nxt = T_SH_WR;
      end
      T_SH_WR: begin
        we    = 1'b1;
        waddr = AW'(j_r);
        wdata = rdata_r;
        if (up_r) begin
          j_nxt     = j_r - TW'(1);
          state_nxt = (j_r - TW'(1) > pos_r) ? T_SH_RD : T_FIN_WR;
        end else begin
          j_nxt = j_r + TW'(1);
          if (j_r + TW'(2) < total_r) begin
            state_nxt = T_SH_RD;
          end else begin
            total_nxt = total_r - TW'(1);
            state_nxt = T_IDLE;
          end
        end
      end
      T_FIN_WR: begin
        we        = 1'b1;
        waddr     = pos_r[AW-1:0];
        wdata     = '{first: base_r, count: cnt_r};
        total_nxt = total_r + TW'(1);
        state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      total_r <= '0;
      found_r <= 1'b0;
      probe_r <= 1'b0;
      up_r    <= 1'b0;
      j_r     <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      found_r <= found_nxt;
      probe_r <= probe_nxt;
      up_r    <= up_nxt;
      j_r     <= j_nxt;
      pos_r   <= pos_nxt;
    end
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign stat.busy  = (state_r != T_IDLE) || cmd.start;
  assign stat.found = found_r;
  assign stat.ovf   = ovf;
  assign hit_first  = cur_r.first;

  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(MAX_RANGES))
    else $error("range table holds more entries than it can");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == T_IDLE)
    else $error("table command issued while busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_SCAN_CHK |-> j_r < total_r)
    else $error("scan checked an entry beyond the table");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ffra_pkg::*;

  localparam int NRANGE = 32;
  localparam int RLIM   = 1 << 20;
  localparam int SLIM   = 1 << 11;
  localparam int NRAND  = 1250;

  typedef struct {
    int unsigned first;
    int unsigned count;
  } span_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] rbase;
    logic [20:0] rcount;
    logic [10:0] sbase;
    logic [11:0] scount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] rfirst;
    logic [10:0] sfirst;
  } grant_t;

  typedef struct {
    req_t   req;
    logic   has_exp;
    grant_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [19:0] in_cbv_base = '0;
  logic [20:0] in_cbv_count = '0;
  logic [10:0] in_sampler_base = '0;
  logic [11:0] in_sampler_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [19:0] out_cbv_first;
  logic [10:0] out_sampler_first;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  first_fit_range_allocator u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_cbv_base, .in_cbv_count,
    .in_sampler_base, .in_sampler_count, .out_valid, .out_ready, .out_status,
    .out_cbv_first, .out_sampler_first, .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // predictor state
  span_t res_tbl[NRANGE];
  span_t smp_tbl[NRANGE];
  int unsigned res_n, smp_n;
  int unsigned res_pool = 4096, smp_pool = 2048;

  grant_t grants_due[$];
  int errors = 0;
  bit hold_off = 0;
  bit stalls_on = 1;

  task automatic report(input string what, input int unsigned got, input int unsigned exp);
    $display("tb: mismatch %s got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  function automatic void tbl_init(ref span_t t[NRANGE], ref int unsigned n,
                                   input int unsigned size, input int unsigned lim);
    if (size > lim) size = lim;
    n = 0;
    if (size != 0) begin
      t[0].first = 0;
      t[0].count = size;
      n = 1;
    end
  endfunction

  function automatic int tbl_find(ref span_t t[NRANGE], input int unsigned n,
                                  input int unsigned cnt);
    for (int i = 0; i < n; i++)
      if (t[i].count >= cnt) return i;
    return -1;
  endfunction

  function automatic void tbl_take(ref span_t t[NRANGE], ref int unsigned n,
                                   input int idx, input int unsigned cnt);
    t[idx].first += cnt;
    t[idx].count -= cnt;
    if (t[idx].count == 0) begin
      for (int i = idx; i < n - 1; i++) t[i] = t[i+1];
      n--;
    end
  endfunction

  function automatic int unsigned clip(input int unsigned b, input int unsigned c,
                                       input int unsigned lim);
    if (b >= lim) return 0;
    if (c > lim - b) return lim - b;
    return c;
  endfunction

  // where a freed range lands; lj and rj flag a join with the left or right neighbour
  function automatic int unsigned tbl_slot(ref span_t t[NRANGE], input int unsigned n,
                                           input int unsigned b, input int unsigned c,
                                           output bit lj, output bit rj);
    int unsigned p;
    p = 0;
    while (p < n && t[p].first < b) p++;
    lj = p > 0 && t[p-1].first + t[p-1].count == b;
    rj = p < n && b + c == t[p].first;
    return p;
  endfunction

  function automatic bit tbl_overflows(ref span_t t[NRANGE], input int unsigned n,
                                       input int unsigned b, input int unsigned c);
    bit lj, rj;
    if (c == 0) return 0;
    void'(tbl_slot(t, n, b, c, lj, rj));
    return !lj && !rj && n >= NRANGE;
  endfunction

  function automatic void tbl_insert(ref span_t t[NRANGE], ref int unsigned n,
                                     input int unsigned b, input int unsigned c);
    bit lj, rj;
    int unsigned p;
    if (c == 0) return;
    p = tbl_slot(t, n, b, c, lj, rj);
    if (lj && rj) begin
      t[p-1].count += c + t[p].count;
      for (int i = p; i < n - 1; i++) t[i] = t[i+1];
      n--;
    end else if (lj) begin
      t[p-1].count += c;
    end else if (rj) begin
      t[p].first = b;
      t[p].count += c;
    end else if (n < NRANGE) begin
      for (int i = n; i > p; i--) t[i] = t[i-1];
      t[p].first = b;
      t[p].count = c;
      n++;
    end
  endfunction

  function automatic grant_t predict_grant(input req_t r);
    grant_t g;
    int ri, si;
    int unsigned rc, sc;
    bit ok;
    g = '0;
    g.status = ST_OK;
    case (op_t'(r.op))
      OP_INIT: begin
        tbl_init(res_tbl, res_n, res_pool, RLIM);
        tbl_init(smp_tbl, smp_n, smp_pool, SLIM);
      end
      OP_ALLOC: begin
        ri = -1; si = -1; ok = 1;
        if (r.rcount != 0) begin
          ri = tbl_find(res_tbl, res_n, 32'(r.rcount));
          ok = ri >= 0;
        end
        if (ok && r.scount != 0) begin
          si = tbl_find(smp_tbl, smp_n, 32'(r.scount));
          ok = si >= 0;
        end
        if (!ok) g.status = ST_NOFIT;
        else begin
          if (ri >= 0) begin
            g.rfirst = 20'(res_tbl[ri].first);
            tbl_take(res_tbl, res_n, ri, 32'(r.rcount));
          end
          if (si >= 0) begin
            g.sfirst = 11'(smp_tbl[si].first);
            tbl_take(smp_tbl, smp_n, si, 32'(r.scount));
          end
        end
      end
      OP_FREE: begin
        rc = clip(32'(r.rbase), 32'(r.rcount), RLIM);
        sc = clip(32'(r.sbase), 32'(r.scount), SLIM);
        if (tbl_overflows(res_tbl, res_n, 32'(r.rbase), rc) ||
            tbl_overflows(smp_tbl, smp_n, 32'(r.sbase), sc))
          g.status = ST_FULL;
        else begin
          tbl_insert(res_tbl, res_n, 32'(r.rbase), rc);
          tbl_insert(smp_tbl, smp_n, 32'(r.sbase), sc);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic send_req(input req_t r, input logic has_exp, input grant_t exp);
    grant_t g;
    g = predict_grant(r);
    if (has_exp && g.status !== exp.status) begin
      report("directed row status", 32'(g.status), 32'(exp.status));
    end
    if (has_exp && g.rfirst !== exp.rfirst) begin
      report("directed row cbv_first", 32'(g.rfirst), 32'(exp.rfirst));
    end
    if (has_exp && g.sfirst !== exp.sfirst) begin
      report("directed row sampler_first", 32'(g.sfirst), 32'(exp.sfirst));
    end
    grants_due.insert(grants_due.size(), g);
    in_operation = r.op;
    in_cbv_base = r.rbase;
    in_cbv_count = r.rcount;
    in_sampler_base = r.sbase;
    in_sampler_count = r.scount;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_valid = 1'b0;
    repeat ($urandom_range(0, 6)) @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (4 * NRANGE + 20) @(negedge clk);
  endtask

  task automatic write_pools(input int unsigned rsz, input int unsigned ssz);
    cfg_we = 1'b1;
    cfg_index = CFG_RES_POOL;
    cfg_wdata = CFG_DATA_W'(rsz);
    res_pool = rsz & 32'h1FFFFF;
    @(negedge clk);
    cfg_index = CFG_SMP_POOL;
    cfg_wdata = CFG_DATA_W'(ssz);
    smp_pool = ssz & 32'hFFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic req_t mk(input op_t op, input int unsigned rb, input int unsigned rc,
                              input int unsigned sb, input int unsigned sc);
    req_t r;
    r.op = op; r.rbase = 20'(rb); r.rcount = 21'(rc); r.sbase = 11'(sb); r.scount = 12'(sc);
    return r;
  endfunction

  function automatic grant_t gr(input status_t s, input int unsigned rf, input int unsigned sf);
    grant_t g;
    g.status = s; g.rfirst = 20'(rf); g.sfirst = 11'(sf);
    return g;
  endfunction

  // random item; mostly well-formed allocate/free traffic
  function automatic req_t rand_req();
    req_t r;
    int unsigned k;
    int idx;
    k = $urandom_range(0, 99);
    r = '0;
    if (k < 3) r.op = OP_INIT;
    else if (k < 5) r.op = OP_NONE;
    else if (k < 50) r.op = OP_ALLOC;
    else r.op = OP_FREE;
    r.rbase = 20'($urandom);
    r.sbase = 11'($urandom);
    case ($urandom_range(0, 3))
      0: r.rcount = 21'($urandom);
      1: r.rcount = 21'($urandom_range(0, 2));
      default: r.rcount = 21'($urandom_range(1, 300));
    endcase
    case ($urandom_range(0, 3))
      0: r.scount = 12'($urandom);
      1: r.scount = 12'($urandom_range(0, 2));
      default: r.scount = 12'($urandom_range(1, 60));
    endcase
    // free just behind an existing range so merges happen
    if (r.op == OP_FREE && $urandom_range(0, 2) != 0) begin
      if (res_n != 0) begin
        idx = $urandom_range(0, res_n - 1);
        r.rbase = 20'(res_tbl[idx].first - 32'(r.rcount[8:0]));
        r.rcount = 21'(r.rcount[8:0]);
      end
      if (smp_n != 0) begin
        idx = $urandom_range(0, smp_n - 1);
        r.sbase = 11'(smp_tbl[idx].first - 32'(r.scount[5:0]));
        r.scount = 12'(r.scount[5:0]);
      end
    end
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        report("unexpected transaction status", 32'(out_status), 0);
      end else begin
        e = grants_due.pop_front();
        if (out_status !== e.status) report("status", 32'(out_status), 32'(e.status));
        if (out_cbv_first !== e.rfirst)
          report("cbv_first", 32'(out_cbv_first), 32'(e.rfirst));
        if (out_sampler_first !== e.sfirst)
          report("sampler_first", 32'(out_sampler_first), 32'(e.sfirst));
      end
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned ph;
    ph = 0;
    forever begin
      @(negedge clk);
      ph++;
      if (hold_off) out_ready <= 1'b0;
      else if (!stalls_on) out_ready <= 1'b1;
      else out_ready <= (ph % 11 < 7) ? ($urandom_range(0, 3) != 0) : ph[4];
    end
  end

  initial begin
    row_t rows[$];
    req_t r;
    int unsigned burst;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 1, 0, 1), 1, gr(ST_NOFIT, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 0, 0, 0), 1, gr(ST_OK, 0, 0)});
    rows.insert(rows.size(),
                '{mk(OP_NONE, 'hFFFFF, 'h1FFFFF, 'h7FF, 'hFFF), 1, gr(ST_OK, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_INIT, 0, 0, 0, 0), 1, gr(ST_OK, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 10, 0, 5), 1, gr(ST_OK, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 4086, 0, 2043), 1, gr(ST_OK, 10, 5)});
    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 1, 0, 0), 1, gr(ST_NOFIT, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_FREE, 100, 50, 200, 20), 1, gr(ST_OK, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_FREE, 150, 10, 180, 20), 0, '0});
    rows.insert(rows.size(), '{mk(OP_FREE, 90, 10, 220, 5), 0, '0});
    rows.insert(rows.size(), '{mk(OP_FREE, 'hFFFFF, 'h1FFFFF, 'h7FF, 'hFFF), 0, '0});
    rows.insert(rows.size(), '{mk(OP_FREE, 5, 0, 3, 0), 0, '0});
    rows.insert(rows.size(), '{mk(OP_FREE, 120, 5, 190, 3), 0, '0});
    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 30, 0, 1), 0, '0});
    rows.insert(rows.size(),
                '{mk(OP_ALLOC, 0, 'h100000, 0, 'h800), 1, gr(ST_NOFIT, 0, 0)});
    rows.insert(rows.size(), '{mk(OP_ALLOC, 0, 2, 0, 1), 0, '0});
    foreach (rows[i]) send_req(rows[i].req, rows[i].has_exp, rows[i].exp);
    drain();

    // overflow one table with isolated single frees
    for (int i = 0; i < NRANGE + 2; i++)
      send_req(mk(OP_FREE, 1000 + 2 * i, 1, 0, 0), 0, '0);
    send_req(mk(OP_FREE, 2000, 1, 0, 0), 1, gr(ST_FULL, 0, 0));
    drain();

    // extremes of pool size, then the long receiver hold-off
    write_pools(0, 0);
    send_req(mk(OP_INIT, 0, 0, 0, 0), 1, gr(ST_OK, 0, 0));
    send_req(mk(OP_ALLOC, 0, 1, 0, 0), 1, gr(ST_NOFIT, 0, 0));
    drain();
    write_pools('h1FFFFF, 'hFFF);
    hold_off = 1;
    send_req(mk(OP_INIT, 0, 0, 0, 0), 1, gr(ST_OK, 0, 0));
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      begin
        send_req(mk(OP_ALLOC, 0, 'h100000, 0, 'h800), 1, gr(ST_OK, 0, 0));
        send_req(mk(OP_FREE, 0, 'h100000, 0, 'h800), 1, gr(ST_OK, 0, 0));
      end
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_pools(4096, 2048);
        1: write_pools(1 << 20, 2048);
        2: write_pools($urandom_range(1, 5000), $urandom_range(1, 300));
        default: write_pools(1 << 20, 'hFFF);
      endcase
      stalls_on = (ph != 2);
      send_req(mk(OP_INIT, 0, 0, 0, 0), 0, '0);
      for (int n = 0; n < NRAND / 4; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < NRAND / 4; b++, n++) begin
          r = rand_req();
          send_req(r, 0, '0);
        end
        if ($urandom_range(0, 3) != 0) idle_gap();
      end
      drain();
    end

    stalls_on = 0;
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_table.sv
hw/rtl/first_fit_range_allocator.sv
dv/tb.sv
